/* rtl/mbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-button debounce package
// Shared widths, register indexes, reset values and the structs that pass
// between the button lanes and the result stage.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int BTN_W           = 8;
    localparam int TIMER_W         = 10;
    localparam int GROUP_W         = 8;
    localparam int PATTERN_W       = 8;
    localparam int POS_W           = 3;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_IDX_W       = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_INTERVAL    = t_cfg_index'(0);
    localparam t_cfg_index CFG_LONG_GROUPS = t_cfg_index'(1);
    localparam t_cfg_index CFG_PRESS_LEVEL = t_cfg_index'(2);

    localparam logic [TIMER_W-1:0]   INTERVAL_RESET    = TIMER_W'(10);
    localparam logic [GROUP_W-1:0]   LONG_GROUPS_RESET = GROUP_W'(18);
    localparam logic                 PRESS_LEVEL_RESET = 1'b0;

    localparam logic [PATTERN_W-1:0] FULL_PATTERN  = {PATTERN_W{1'b1}};
    localparam logic [POS_W-1:0]     LAST_POSITION = POS_W'(7);

    typedef struct packed {
        logic [TIMER_W-1:0] interval_ticks;
        logic [GROUP_W-1:0] long_groups;
        logic               press_level;
    } t_cfg;

    typedef struct packed {
        logic short_held;
        logic long_held;
        logic short_event;
        logic long_event;
    } t_lane_status;

endpackage
`default_nettype wire

/* rtl/mbd_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel carrying one beat of sampled button levels per tick.
// ----------------------------------------------------------------------------
interface mbd_in_if;
    logic                     valid;
    logic                     ready;
    logic [mbd_pkg::BTN_W-1:0] button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface
`default_nettype wire

/* rtl/mbd_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Press result channel
// Valid/ready channel carrying one beat of held flags and event pulses.
// ----------------------------------------------------------------------------
interface mbd_out_if;
    logic                     valid;
    logic                     ready;
    logic [mbd_pkg::BTN_W-1:0] short_held;
    logic [mbd_pkg::BTN_W-1:0] long_held;
    logic [mbd_pkg::BTN_W-1:0] short_event;
    logic [mbd_pkg::BTN_W-1:0] long_event;

    modport source (output valid, output short_held, output long_held,
                    output short_event, output long_event, input ready);
    modport sink   (input valid, input short_held, input long_held,
                    input short_event, input long_event, output ready);
endinterface
`default_nettype wire

/* rtl/multi_button_debounce_long_press_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-button debounce with short and long press detection
// A tick beat's result is valid in the cycle after the beat is taken.
// Throughput: one tick beat per cycle, set by the single lane update step and
// the output register, which accepts a new beat whenever it is empty or taken.
// Reset clears all button state and the output valid flag and loads the
// configuration registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mbd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mbd_in_if.sink                              i_in,
    mbd_out_if.source                           o_out
);
    import mbd_pkg::*;

    t_cfg         r_cfg;
    t_lane_status w_status [NUM_BUTTONS];
    logic         w_can_load;
    logic         w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ticks <= INTERVAL_RESET;
            r_cfg.long_groups    <= LONG_GROUPS_RESET;
            r_cfg.press_level    <= PRESS_LEVEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INTERVAL: begin
                    r_cfg.interval_ticks <= i_cfg_wdata[TIMER_W-1:0];
                end
                CFG_LONG_GROUPS: begin
                    r_cfg.long_groups <= i_cfg_wdata[GROUP_W-1:0];
                end
                CFG_PRESS_LEVEL: begin
                    r_cfg.press_level <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = w_can_load;
    assign w_step     = i_in.valid && w_can_load;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic w_level;
        if (b < BTN_W) begin : g_in
            assign w_level = i_in.button_levels[b];
        end else begin : g_zero
            assign w_level = 1'b0;
        end
        mbd_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_step),
            .i_level  (w_level),
            .i_cfg    (r_cfg),
            .o_status (w_status[b])
        );
    end

    mbd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step),
        .i_status   (w_status),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

    a_event_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (((o_out.short_event & ~o_out.short_held) == '0) &&
                         ((o_out.long_event & ~o_out.long_held) == '0)))
        else $error("event reported without its held flag");

    a_long_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.long_held & ~o_out.short_held) == '0))
        else $error("long press held without short press");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output register is empty");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("accepted beat produced no result");

endmodule
`default_nettype wire

/* rtl/mbd_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Button lane
// Per-button timer, sample pattern, group counter and press flags, advanced
// once per accepted tick beat.
// ----------------------------------------------------------------------------
module mbd_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_level,
    input  wire mbd_pkg::t_cfg         i_cfg,
    output mbd_pkg::t_lane_status      o_status
);
    import mbd_pkg::*;

    logic [TIMER_W-1:0]   r_timer,   n_timer;
    logic [PATTERN_W-1:0] r_pattern, n_pattern;
    logic [POS_W-1:0]     r_pos,     n_pos;
    logic [GROUP_W-1:0]   r_group,   n_group;
    logic                 r_short,   n_short;
    logic                 r_long,    n_long;
    logic                 r_short_rep, n_short_rep;
    logic                 r_long_rep,  n_long_rep;

    logic [PATTERN_W-1:0] w_pattern_set;
    logic [GROUP_W-1:0]   w_group_fire;
    logic                 w_short_fire;

    always_comb begin
        n_timer       = r_timer;
        n_pattern     = r_pattern;
        n_pos         = r_pos;
        n_group       = r_group;
        n_short       = r_short;
        n_long        = r_long;
        w_pattern_set = r_pattern | (PATTERN_W'(1) << r_pos);
        w_short_fire  = r_short;
        w_group_fire  = r_group;
        if (i_level != i_cfg.press_level) begin
            n_timer   = '0;
            n_pattern = '0;
            n_pos     = '0;
            n_group   = '0;
            n_short   = 1'b0;
            n_long    = 1'b0;
        end else if (r_timer != i_cfg.interval_ticks) begin
            n_timer = r_timer + TIMER_W'(1);
        end else begin
            n_timer   = '0;
            n_pattern = w_pattern_set;
            if (w_pattern_set == FULL_PATTERN) begin
                w_short_fire = 1'b1;
                n_pattern    = '0;
                w_group_fire = r_group + GROUP_W'(1);
            end
            n_short = w_short_fire;
            n_group = w_group_fire;
            if (w_short_fire && (w_group_fire >= i_cfg.long_groups)) begin
                n_long  = 1'b1;
                n_group = '0;
            end
            n_pos = (r_pos == LAST_POSITION) ? '0 : r_pos + POS_W'(1);
        end
        n_short_rep = r_short_rep & n_short;
        n_long_rep  = r_long_rep & n_long;
        if (n_short) begin
            n_short_rep = 1'b1;
        end
        if (n_long) begin
            n_long_rep = 1'b1;
        end
    end

    always_comb begin
        o_status.short_held  = n_short;
        o_status.long_held   = n_long;
        o_status.short_event = n_short & ~(r_short_rep & r_short);
        o_status.long_event  = n_long & ~(r_long_rep & r_long);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_pattern   <= '0;
            r_pos       <= '0;
            r_group     <= '0;
            r_short     <= 1'b0;
            r_long      <= 1'b0;
            r_short_rep <= 1'b0;
            r_long_rep  <= 1'b0;
        end else if (i_step) begin
            r_timer     <= n_timer;
            r_pattern   <= n_pattern;
            r_pos       <= n_pos;
            r_group     <= n_group;
            r_short     <= n_short;
            r_long      <= n_long;
            r_short_rep <= n_short_rep;
            r_long_rep  <= n_long_rep;
        end
    end

endmodule
`default_nettype wire

/* rtl/mbd_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result merge stage
// Gathers the lane status into the output vectors and holds the result beat
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module mbd_merge #(
    parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire mbd_pkg::t_lane_status i_status [NUM_BUTTONS],
    output logic                      o_can_load,
    mbd_out_if.source                 o_out
);
    import mbd_pkg::*;

    logic             r_valid;
    logic [BTN_W-1:0] r_short_held, n_short_held;
    logic [BTN_W-1:0] r_long_held,  n_long_held;
    logic [BTN_W-1:0] r_short_evt,  n_short_evt;
    logic [BTN_W-1:0] r_long_evt,   n_long_evt;

    for (genvar b = 0; b < BTN_W; b++) begin : g_bit
        if (b < NUM_BUTTONS) begin : g_lane
            assign n_short_held[b] = i_status[b].short_held;
            assign n_long_held[b]  = i_status[b].long_held;
            assign n_short_evt[b]  = i_status[b].short_event;
            assign n_long_evt[b]   = i_status[b].long_event;
        end else begin : g_none
            assign n_short_held[b] = 1'b0;
            assign n_long_held[b]  = 1'b0;
            assign n_short_evt[b]  = 1'b0;
            assign n_long_evt[b]   = 1'b0;
        end
    end

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_short_held <= n_short_held;
            r_long_held  <= n_long_held;
            r_short_evt  <= n_short_evt;
            r_long_evt   <= n_long_evt;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.short_held  = r_short_held;
    assign o_out.long_held   = r_long_held;
    assign o_out.short_event = r_short_evt;
    assign o_out.long_event  = r_long_evt;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Multi-button debounce regression bench
// Feeds one beat of button levels per tick through the valid/ready
// channels under random source gaps and sink stalls. A behavioral tracker of
// the per-button timers, patterns, group counts and flags predicts every
// result beat, which is compared field by field. Directed holds come first,
// then random press/release sequences under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_WAIT      = 19;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [BTN_W-1:0] short_held;
        logic [BTN_W-1:0] long_held;
        logic [BTN_W-1:0] short_event;
        logic [BTN_W-1:0] long_event;
    } t_press_report;

    typedef struct {
        logic [BTN_W-1:0] levels;
        int unsigned      gap;
    } t_tick_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    mbd_in_if  tick_ch ();
    mbd_out_if report_ch ();

    multi_button_debounce_long_press_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (tick_ch),
        .o_out       (report_ch)
    );

    logic [TIMER_W-1:0]   btn_timer   [BTN_W];
    logic [PATTERN_W-1:0] btn_pattern [BTN_W];
    logic [POS_W-1:0]     btn_pos     [BTN_W];
    logic [GROUP_W-1:0]   btn_groups  [BTN_W];
    logic [BTN_W-1:0]     short_flags;
    logic [BTN_W-1:0]     long_flags;
    logic [BTN_W-1:0]     short_told;
    logic [BTN_W-1:0]     long_told;
    logic [TIMER_W-1:0]   cur_interval;
    logic [GROUP_W-1:0]   cur_long_groups;
    logic                 cur_press_level;

    t_press_report expected_reports [$];
    t_tick_beat    pending_ticks [$];

    int unsigned sent_ticks;
    int unsigned checked_reports;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned short_reports;
    int unsigned long_reports;
    int unsigned register_writes;

    bit          tick_taken;
    bit          tick_busy;
    int unsigned tick_wait;
    bit          tick_idling;
    int unsigned tick_mode_left;
    int unsigned report_stall;
    bit          report_idling;
    int unsigned report_mode_left;

    int unsigned gen_interval;
    int unsigned gen_groups;
    bit          gen_press;
    int unsigned hold_left    [BTN_W];
    bit          hold_pressed [BTN_W];

    function automatic void clear_tracker();
        int b;
        for (b = 0; b < BTN_W; b++) begin
            btn_timer[b]   = '0;
            btn_pattern[b] = '0;
            btn_pos[b]     = '0;
            btn_groups[b]  = '0;
        end
        short_flags     = '0;
        long_flags      = '0;
        short_told      = '0;
        long_told       = '0;
        cur_interval    = INTERVAL_RESET;
        cur_long_groups = LONG_GROUPS_RESET;
        cur_press_level = PRESS_LEVEL_RESET;
    endfunction

    function automatic t_press_report track_tick(logic [BTN_W-1:0] levels);
        t_press_report rep;
        int b;
        for (b = 0; b < BTN_W; b++) begin
            if (levels[b] != cur_press_level) begin
                btn_timer[b]   = '0;
                btn_pattern[b] = '0;
                btn_pos[b]     = '0;
                btn_groups[b]  = '0;
                short_flags[b] = 1'b0;
                long_flags[b]  = 1'b0;
                short_told[b]  = 1'b0;
                long_told[b]   = 1'b0;
            end else if (btn_timer[b] != cur_interval) begin
                btn_timer[b] = btn_timer[b] + 1'b1;
            end else begin
                btn_timer[b] = '0;
                btn_pattern[b][btn_pos[b]] = 1'b1;
                if (btn_pattern[b] == FULL_PATTERN) begin
                    short_flags[b] = 1'b1;
                    btn_pattern[b] = '0;
                    btn_groups[b]  = btn_groups[b] + 1'b1;
                end
                if (short_flags[b] && btn_groups[b] >= cur_long_groups) begin
                    long_flags[b] = 1'b1;
                    btn_groups[b] = '0;
                end
                btn_pos[b] = (btn_pos[b] >= LAST_POSITION) ? '0 : btn_pos[b] + 1'b1;
            end
        end
        rep.short_event = short_flags & ~short_told;
        rep.long_event  = long_flags & ~long_told;
        short_told      = short_told | short_flags;
        long_told       = long_told | long_flags;
        rep.short_held  = short_flags;
        rep.long_held   = long_flags;
        return rep;
    endfunction

    function automatic void check_field(string field, logic [BTN_W-1:0] want,
                                        logic [BTN_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, field, want, got);
        end
    endfunction

    function automatic logic [BTN_W-1:0] next_levels(logic [BTN_W-1:0] held_mask);
        logic [BTN_W-1:0] levels;
        int unsigned short_len;
        int unsigned full_len;
        int b;
        short_len = 8 * (gen_interval + 1);
        full_len  = short_len * (gen_groups + 1) + 8;
        if (full_len > 400)
            full_len = 400;
        for (b = 0; b < BTN_W; b++) begin
            if (held_mask[b]) begin
                levels[b] = gen_press;
            end else begin
                if (hold_left[b] == 0) begin
                    hold_pressed[b] = ($urandom_range(0, 9) < 7);
                    if (!hold_pressed[b]) begin
                        hold_left[b] = $urandom_range(1, 6);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: hold_left[b] = $urandom_range(1, short_len + 2);
                            1: hold_left[b] = $urandom_range(short_len, 2 * short_len + 4);
                            default: hold_left[b] = $urandom_range(short_len, full_len);
                        endcase
                    end
                end
                hold_left[b]--;
                levels[b] = hold_pressed[b] ? gen_press : !gen_press;
                if ($urandom_range(0, 39) == 0)
                    levels[b] = !levels[b];
            end
        end
        return levels;
    endfunction

    task automatic push_tick(logic [BTN_W-1:0] levels);
        t_tick_beat beat;
        if (tick_mode_left == 0) begin
            tick_idling    = ($urandom_range(0, 3) != 0);
            tick_mode_left = $urandom_range(20, 60);
        end
        tick_mode_left--;
        beat.levels = levels;
        beat.gap    = tick_idling ? $urandom_range(0, MAX_WAIT) : 0;
        pending_ticks.push_back(beat);
        sent_ticks++;
    endtask

    task automatic push_random_ticks(int unsigned count, logic [BTN_W-1:0] held_mask);
        logic [BTN_W-1:0] levels;
        repeat (count) begin
            levels = next_levels(held_mask);
            if ($urandom_range(0, 29) == 0)
                levels = levels ^ (BTN_W'($urandom) & ~held_mask);
            push_tick(levels);
        end
    endtask

    task automatic write_register(t_cfg_index reg_index, int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        register_writes++;
    endtask

    task automatic apply_setting(int unsigned interval, int unsigned groups, bit level);
        write_register(CFG_INTERVAL, interval);
        write_register(CFG_LONG_GROUPS, groups);
        write_register(CFG_PRESS_LEVEL, level);
        gen_interval = interval;
        gen_groups   = groups;
        gen_press    = level;
    endtask

    task automatic wait_idle();
        while (checked_reports < sent_ticks)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin : tick_driver
        t_tick_beat beat;
        if (!i_rst_n) begin
            tick_ch.valid         <= 1'b0;
            tick_ch.button_levels <= '0;
        end else begin
            if (tick_taken) begin
                tick_taken = 1'b0;
                tick_busy  = 1'b0;
            end
            if (!tick_busy) begin
                if (pending_ticks.size() != 0 && tick_wait >= pending_ticks[0].gap) begin
                    beat = pending_ticks.pop_front();
                    tick_ch.valid         <= 1'b1;
                    tick_ch.button_levels <= beat.levels;
                    tick_busy = 1'b1;
                    tick_wait = 0;
                end else begin
                    tick_ch.valid <= 1'b0;
                    if (pending_ticks.size() != 0)
                        tick_wait++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : report_sink
        if (!i_rst_n) begin
            report_ch.ready <= 1'b0;
        end else if (report_stall != 0) begin
            report_ch.ready <= 1'b0;
            report_stall--;
        end else begin
            report_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : report_monitor
        t_press_report want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, checked_reports, sent_ticks);
            $display("[FAIL] regression broken");
            $finish;
        end else if (!i_rst_n) begin
            clear_tracker();
        end else begin
            if (report_ch.valid && report_ch.ready) begin
                checked_reports++;
                if (report_mode_left == 0) begin
                    report_idling    = ($urandom_range(0, 3) != 0);
                    report_mode_left = $urandom_range(20, 60);
                end
                report_mode_left--;
                report_stall = report_idling ? $urandom_range(0, MAX_WAIT) : 0;
                if (expected_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result beat, expected none, actual %08h",
                             $time, {report_ch.short_held, report_ch.long_held,
                                     report_ch.short_event, report_ch.long_event});
                end else begin
                    want = expected_reports.pop_front();
                    check_field("short_held", want.short_held, report_ch.short_held);
                    check_field("long_held", want.long_held, report_ch.long_held);
                    check_field("short_event", want.short_event, report_ch.short_event);
                    check_field("long_event", want.long_event, report_ch.long_event);
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                want = track_tick(tick_ch.button_levels);
                short_reports += $countones(want.short_event);
                long_reports  += $countones(want.long_event);
                expected_reports.push_back(want);
                tick_taken = 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL:    cur_interval    = i_cfg_wdata[TIMER_W-1:0];
                    CFG_LONG_GROUPS: cur_long_groups = i_cfg_wdata[GROUP_W-1:0];
                    CFG_PRESS_LEVEL: cur_press_level = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    initial begin : stimulus
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = CFG_INTERVAL;
        i_cfg_wdata           = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.button_levels = '0;
        report_ch.ready       = 1'b0;
        gen_interval          = INTERVAL_RESET;
        gen_groups            = LONG_GROUPS_RESET;
        gen_press             = PRESS_LEVEL_RESET;
        clear_tracker();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: all released, all pressed, then released again.
        push_tick(8'hFF);
        push_tick(8'h00);
        push_tick(8'h00);
        push_tick(8'hFF);
        wait_idle();

        // Fastest timer with one group: short and long land on the same firing.
        apply_setting(0, 1, 1'b1);
        repeat (10) push_tick(8'hFF);
        push_tick(8'h0F);
        push_tick(8'hFF);
        push_tick(8'hFF);
        wait_idle();

        // A group threshold of zero flags long on every firing once short is set.
        write_register(CFG_LONG_GROUPS, 0);
        repeat (9) push_tick(8'h3C);
        wait_idle();

        // Slowest timer, then lower the interval under the running timers so
        // the two held buttons must wrap around before they fire again.
        apply_setting(1023, 3, 1'b0);
        repeat (16) push_tick(8'h00);
        wait_idle();
        write_register(CFG_INTERVAL, 2);
        gen_interval = 2;
        push_random_ticks(1060, 8'h03);
        wait_idle();

        apply_setting(0, 255, 1'b1);
        push_random_ticks(60, 8'h00);
        wait_idle();

        apply_setting(5, 2, 1'b0);
        push_random_ticks(90, 8'h00);
        wait_idle();

        if (expected_reports.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected result beats never arrived",
                     $time, expected_reports.size());
        end
        $display("Sent %0d tick beats across %0d register writes, including a timer wrap.",
                 sent_ticks, register_writes);
        $display("Compared %0d result beats holding %0d short and %0d long reports.",
                 checked_reports, short_reports, long_reports);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
